// File: hdl/usrh_pkg.sv
package usrh_pkg;

   localparam int ENDPOINT_SLOTS = 16;

   typedef enum logic [1:0] {
      HS_ACK     = 2'd0,
      HS_STALL   = 2'd1,
      HS_NONE    = 2'd2,
      HS_FORWARD = 2'd3
   } handshake_type;

   localparam logic [7:0] REQ_GET_STATUS    = 8'h00;
   localparam logic [7:0] REQ_CLEAR_FEATURE = 8'h01;
   localparam logic [7:0] REQ_SET_FEATURE   = 8'h03;
   localparam logic [7:0] REQ_SET_ADDRESS   = 8'h05;
   localparam logic [7:0] REQ_GET_DESC      = 8'h06;
   localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
   localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
   localparam logic [7:0] REQ_GET_INTERFACE = 8'h0a;
   localparam logic [7:0] REQ_SET_INTERFACE = 8'h0b;
   localparam logic [7:0] REQ_SYNCH_FRAME   = 8'h0c;

   localparam logic [7:0] RT_DEVICE_OUT   = 8'h00;
   localparam logic [7:0] RT_ENDPOINT_OUT = 8'h02;
   localparam logic [7:0] RT_DEVICE_IN    = 8'h80;
   localparam logic [7:0] RT_INTERFACE_IN = 8'h81;
   localparam logic [7:0] RT_ENDPOINT_IN  = 8'h82;

   localparam logic [7:0] FEAT_ENDPOINT_HALT = 8'h00;
   localparam logic [7:0] FEAT_REMOTE_WAKEUP = 8'h01;

   typedef logic [3:0] slot_type;

   function automatic slot_type slot_of(input logic [7:0] addr);
      return {addr[7], addr[2:0]};
   endfunction

endpackage

// File: hdl/usrh_if.sv
interface usrh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] request_type;
   logic [7:0] request_code;
   logic [7:0] value_low;
   logic [7:0] value_high;
   logic [7:0] index_low;

   modport source (output valid, request_type, request_code, value_low, value_high,
                   index_low, input ready);
   modport sink (input valid, request_type, request_code, value_low, value_high,
                 index_low, output ready);
endinterface

interface usrh_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] handshake;
   logic [7:0] reply_first;
   logic [7:0] reply_second;
   logic [1:0] reply_count;

   modport source (output valid, handshake, reply_first, reply_second, reply_count,
                   input ready);
   modport sink (input valid, handshake, reply_first, reply_second, reply_count,
                 output ready);
endinterface

interface usrh_csr_if;
   logic valid;
   logic ready;
   logic self_powered;

   modport source (output valid, self_powered, input ready);
   modport sink (input valid, self_powered, output ready);
endinterface

// File: hdl/usb_standard_request_handler.sv
// An accepted item passes the input register and then the result register before its result is valid.
// Throughput: one item per cycle while the response side is ready; the state update happens as an item moves into the
// result register, so the next item already sees it.
// Reset (synchronous, active high): remote wakeup, configuration, halt bits and
// self powered cleared, both stages empty.
module usb_standard_request_handler (
   input logic clock,
   input logic reset,
   usrh_req_if.sink   req_bus,
   usrh_rsp_if.source rsp_bus,
   usrh_csr_if.sink   csr_bus
);
   import usrh_pkg::*;

   logic                      s1_valid_ff;
   logic [7:0]                s1_rtype_ff;
   logic [7:0]                s1_code_ff;
   logic [7:0]                s1_vlow_ff;
   logic [7:0]                s1_ilow_ff;

   logic                      rsp_valid_ff;
   handshake_type             rsp_hs_ff;
   logic [7:0]                rsp_first_ff;
   logic [1:0]                rsp_count_ff;

   logic                      self_powered_ff;
   logic                      remote_wakeup_ff;
   logic                      remote_wakeup_in;
   logic [7:0]                current_config_ff;
   logic [7:0]                current_config_in;
   logic [ENDPOINT_SLOTS-1:0] halt_ff;
   logic [ENDPOINT_SLOTS-1:0] halt_in;

   logic                      advance;
   logic                      req_take;
   slot_type                  slot;
   logic                      halt_bit;
   handshake_type             hs_in;
   logic [7:0]                first_in;
   logic [1:0]                count_in;

   assign advance        = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready  = !s1_valid_ff || advance;
   assign req_take       = req_bus.valid && req_bus.ready;
   assign csr_bus.ready  = 1'b1;

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.handshake    = rsp_hs_ff;
   assign rsp_bus.reply_first  = rsp_first_ff;
   assign rsp_bus.reply_second = 8'h00;
   assign rsp_bus.reply_count  = rsp_count_ff;

   assign slot = slot_of(s1_ilow_ff);

   always_comb begin
      halt_bit = 1'b0;
      for (int i = 0; i < ENDPOINT_SLOTS; i++) begin
         if (int'(slot) == i) begin
            halt_bit = halt_ff[i];
         end
      end
   end

   always_comb begin
      hs_in             = HS_STALL;
      first_in          = 8'h00;
      count_in          = 2'd0;
      remote_wakeup_in  = remote_wakeup_ff;
      current_config_in = current_config_ff;
      halt_in           = halt_ff;
      case (s1_code_ff)
         REQ_GET_STATUS: begin
            if (s1_rtype_ff == RT_DEVICE_IN) begin
               first_in = {6'd0, remote_wakeup_ff, self_powered_ff};
               count_in = 2'd2;
               hs_in    = HS_ACK;
            end else if (s1_rtype_ff == RT_INTERFACE_IN) begin
               count_in = 2'd2;
               hs_in    = HS_ACK;
            end else if (s1_rtype_ff == RT_ENDPOINT_IN) begin
               first_in = {7'd0, halt_bit};
               count_in = 2'd2;
               hs_in    = HS_ACK;
            end
         end
         REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
            if (s1_rtype_ff == RT_DEVICE_OUT && s1_vlow_ff == FEAT_REMOTE_WAKEUP) begin
               remote_wakeup_in = (s1_code_ff == REQ_SET_FEATURE);
               hs_in            = HS_ACK;
            end else if (s1_rtype_ff == RT_ENDPOINT_OUT &&
                         s1_vlow_ff == FEAT_ENDPOINT_HALT) begin
               for (int i = 0; i < ENDPOINT_SLOTS; i++) begin
                  if (int'(slot) == i) begin
                     halt_in[i] = (s1_code_ff == REQ_SET_FEATURE);
                  end
               end
               hs_in = HS_ACK;
            end
         end
         REQ_SET_ADDRESS, REQ_SYNCH_FRAME: begin
            hs_in = HS_NONE;
         end
         REQ_GET_DESC: begin
            hs_in = HS_FORWARD;
         end
         REQ_GET_CONFIG: begin
            first_in = current_config_ff;
            count_in = 2'd1;
            hs_in    = HS_ACK;
         end
         REQ_SET_CONFIG: begin
            current_config_in = s1_vlow_ff;
            hs_in             = HS_ACK;
         end
         REQ_GET_INTERFACE: begin
            count_in = 2'd1;
            hs_in    = HS_ACK;
         end
         REQ_SET_INTERFACE: begin
            hs_in = HS_ACK;
         end
         default: begin
            hs_in = HS_STALL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         self_powered_ff   <= 1'b0;
         remote_wakeup_ff  <= 1'b0;
         current_config_ff <= 8'h00;
         halt_ff           <= '0;
      end else begin
         if (csr_bus.valid) begin
            self_powered_ff <= csr_bus.self_powered;
         end
         if (req_bus.ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (advance && s1_valid_ff) begin
            remote_wakeup_ff  <= remote_wakeup_in;
            current_config_ff <= current_config_in;
            halt_ff           <= halt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_rtype_ff <= req_bus.request_type;
         s1_code_ff  <= req_bus.request_code;
         s1_vlow_ff  <= req_bus.value_low;
         s1_ilow_ff  <= req_bus.index_low;
      end
      if (advance && s1_valid_ff) begin
         rsp_hs_ff    <= hs_in;
         rsp_first_ff <= first_in;
         rsp_count_ff <= count_in;
      end
   end

   a_no_data_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hs_ff != HS_ACK |-> rsp_count_ff == 2'd0 && rsp_first_ff == 8'h00)
      else $error("reply data on a result without data stage");

   a_hold_stage: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_code_ff))
      else $error("input stage lost an item while the result was stalled");

   a_state_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      !(advance && s1_valid_ff) |=> $stable(current_config_ff) && $stable(halt_ff))
      else $error("request state changed without an item moving forward");

endmodule

// File: bench/usb_standard_request_handler_test.sv
`timescale 1ns / 100ps

module usb_standard_request_handler_test;
   import usrh_pkg::*;

   localparam logic [7:0] REQ_PRIVATE_DIAG = 8'h66;
   localparam int PHASE_ITEMS = 460;

   typedef struct packed {
      logic [7:0] request_type;
      logic [7:0] request_code;
      logic [7:0] value_low;
      logic [7:0] value_high;
      logic [7:0] index_low;
   } setup_type;

   typedef struct packed {
      handshake_type handshake;
      logic [7:0]    reply_first;
      logic [7:0]    reply_second;
      logic [1:0]    reply_count;
   } reply_type;

   typedef struct packed {
      setup_type setup;
      logic      pinned;
      reply_type reply;
   } script_row_type;

   typedef struct packed {
      logic      pinned;
      reply_type reply;
   } pin_type;

   localparam reply_type FREE = '{HS_ACK, 8'h00, 8'h00, 2'd0};

   logic clock = 1'b0;
   logic reset;

   usrh_req_if req_ch ();
   usrh_rsp_if rsp_ch ();
   usrh_csr_if csr_ch ();

   usb_standard_request_handler u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   always #5 clock = ~clock;

   logic       powered_now;
   logic       wakeup_now;
   logic [7:0] config_now;
   logic       halt_now [ENDPOINT_SLOTS];

   reply_type pending_replies [$];
   pin_type   pin_q [$];
   int        accepted = 0;
   int        answered = 0;
   int        fault_count = 0;
   int        idle_pct = 27;
   int        tally [4] = '{0, 0, 0, 0};

   function automatic reply_type decode_request(input setup_type s);
      reply_type  r;
      logic [4:0] slot;
      logic       set_bit;
      r = '{HS_STALL, 8'h00, 8'h00, 2'd0};
      slot = {1'b0, s.index_low[7], s.index_low[2:0]};
      set_bit = (s.request_code == REQ_SET_FEATURE);
      case (s.request_code)
         REQ_GET_STATUS: begin
            if (s.request_type == RT_DEVICE_IN) begin
               r = '{HS_ACK, {6'd0, wakeup_now, powered_now}, 8'h00, 2'd2};
            end else if (s.request_type == RT_INTERFACE_IN) begin
               r = '{HS_ACK, 8'h00, 8'h00, 2'd2};
            end else if (s.request_type == RT_ENDPOINT_IN) begin
               r = '{HS_ACK, 8'h00, 8'h00, 2'd2};
               if (slot < ENDPOINT_SLOTS) r.reply_first = {7'd0, halt_now[slot]};
            end
         end
         REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
            if (s.request_type == RT_DEVICE_OUT && s.value_low == FEAT_REMOTE_WAKEUP) begin
               wakeup_now = set_bit;
               r.handshake = HS_ACK;
            end else if (s.request_type == RT_ENDPOINT_OUT
                         && s.value_low == FEAT_ENDPOINT_HALT) begin
               if (slot < ENDPOINT_SLOTS) halt_now[slot] = set_bit;
               r.handshake = HS_ACK;
            end
         end
         REQ_SET_ADDRESS, REQ_SYNCH_FRAME: r.handshake = HS_NONE;
         REQ_GET_DESC: r.handshake = HS_FORWARD;
         REQ_GET_CONFIG: r = '{HS_ACK, config_now, 8'h00, 2'd1};
         REQ_SET_CONFIG: begin
            config_now = s.value_low;
            r.handshake = HS_ACK;
         end
         REQ_GET_INTERFACE: r = '{HS_ACK, 8'h00, 8'h00, 2'd1};
         REQ_SET_INTERFACE: r.handshake = HS_ACK;
         default: r.handshake = HS_STALL;
      endcase
      return r;
   endfunction

   function automatic setup_type random_setup();
      setup_type s;
      int        pick;
      s = {$urandom(), 8'($urandom())};
      pick = $urandom_range(99);
      if (pick < 80) begin
         case ($urandom_range(9))
            0: begin
               s.request_code = REQ_GET_STATUS;
               case ($urandom_range(2))
                  0: s.request_type = RT_DEVICE_IN;
                  1: s.request_type = RT_INTERFACE_IN;
                  default: s.request_type = RT_ENDPOINT_IN;
               endcase
            end
            1, 2: begin
               s.request_code = $urandom_range(1) ? REQ_SET_FEATURE : REQ_CLEAR_FEATURE;
               if ($urandom_range(2) == 0) begin
                  s.request_type = RT_DEVICE_OUT;
                  s.value_low = FEAT_REMOTE_WAKEUP;
               end else begin
                  s.request_type = RT_ENDPOINT_OUT;
                  s.value_low = FEAT_ENDPOINT_HALT;
               end
            end
            3: s.request_code = $urandom_range(1) ? REQ_SET_ADDRESS : REQ_SYNCH_FRAME;
            4: s.request_code = REQ_GET_DESC;
            5: s.request_code = REQ_GET_CONFIG;
            6: s.request_code = REQ_SET_CONFIG;
            7: s.request_code = REQ_GET_INTERFACE;
            8: s.request_code = REQ_SET_INTERFACE;
            default: s.request_code = REQ_GET_STATUS;
         endcase
      end else if (pick < 90) begin
         case ($urandom_range(3))
            0: s.request_code = REQ_GET_STATUS;
            1: s.request_code = REQ_CLEAR_FEATURE;
            2: s.request_code = REQ_SET_FEATURE;
            default: s.request_code = REQ_PRIVATE_DIAG;
         endcase
      end
      return s;
   endfunction

   task automatic log_fault(input string what, input reply_type want, input reply_type got);
      if (fault_count < 10) begin
         $display("%0t %s: expected hs %0d first %02h second %02h count %0d,",
                  $time, what, want.handshake, want.reply_first, want.reply_second,
                  want.reply_count);
         $display("   got hs %0d first %02h second %02h count %0d",
                  got.handshake, got.reply_first, got.reply_second, got.reply_count);
      end
      fault_count++;
   endtask

   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      pin_type   pin;
      setup_type s;
      if (reset) begin
         powered_now = 1'b0;
         wakeup_now = 1'b0;
         config_now = 8'h00;
         for (int i = 0; i < ENDPOINT_SLOTS; i++) halt_now[i] = 1'b0;
         pending_replies.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) powered_now = csr_ch.self_powered;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{handshake_type'(rsp_ch.handshake), rsp_ch.reply_first,
                    rsp_ch.reply_second, rsp_ch.reply_count};
            answered++;
            tally[got.handshake]++;
            if (pending_replies.size() == 0) begin
               log_fault("result with nothing pending", FREE, got);
            end else begin
               want = pending_replies.pop_front();
               if (got !== want) log_fault("mismatch", want, got);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            s = '{req_ch.request_type, req_ch.request_code, req_ch.value_low,
                  req_ch.value_high, req_ch.index_low};
            pin = pin_q.pop_front();
            want = decode_request(s);
            if (pin.pinned) want = pin.reply;
            pending_replies.push_back(want);
         end
      end
   end

   always @(posedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= idle_pct);
   end

   task automatic send_setup(input script_row_type row);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      pin_q.push_back('{row.pinned, row.reply});
      req_ch.valid        <= 1'b1;
      req_ch.request_type <= row.setup.request_type;
      req_ch.request_code <= row.setup.request_code;
      req_ch.value_low    <= row.setup.value_low;
      req_ch.value_high   <= row.setup.value_high;
      req_ch.index_low    <= row.setup.index_low;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      accepted++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (answered < accepted) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_powered(input logic v);
      csr_ch.valid        <= 1'b1;
      csr_ch.self_powered <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      script_row_type script [26];
      logic           powered_plan [4];
      int             idle_plan [4];
      script = '{
         '{'{RT_DEVICE_IN, REQ_GET_STATUS, 8'h00, 8'h00, 8'h00}, 1'b1,
           '{HS_ACK, 8'h00, 8'h00, 2'd2}},
         '{'{RT_INTERFACE_IN, REQ_GET_STATUS, 8'hff, 8'hff, 8'hff}, 1'b1,
           '{HS_ACK, 8'h00, 8'h00, 2'd2}},
         '{'{RT_ENDPOINT_IN, REQ_GET_STATUS, 8'h00, 8'h00, 8'h81}, 1'b1,
           '{HS_ACK, 8'h00, 8'h00, 2'd2}},
         '{'{RT_DEVICE_OUT, REQ_SET_FEATURE, FEAT_REMOTE_WAKEUP, 8'h00, 8'h00}, 1'b1,
           '{HS_ACK, 8'h00, 8'h00, 2'd0}},
         '{'{RT_DEVICE_IN, REQ_GET_STATUS, 8'h00, 8'h00, 8'h00}, 1'b0, FREE},
         '{'{RT_ENDPOINT_OUT, REQ_SET_FEATURE, FEAT_ENDPOINT_HALT, 8'h00, 8'h87}, 1'b1,
           '{HS_ACK, 8'h00, 8'h00, 2'd0}},
         '{'{RT_ENDPOINT_IN, REQ_GET_STATUS, 8'h00, 8'h00, 8'h87}, 1'b0, FREE},
         '{'{RT_ENDPOINT_OUT, REQ_SET_FEATURE, FEAT_ENDPOINT_HALT, 8'hff, 8'h08}, 1'b0, FREE},
         '{'{RT_ENDPOINT_IN, REQ_GET_STATUS, 8'h00, 8'h00, 8'h00}, 1'b0, FREE},
         '{'{RT_ENDPOINT_IN, REQ_GET_STATUS, 8'h00, 8'h00, 8'hff}, 1'b0, FREE},
         '{'{RT_ENDPOINT_OUT, REQ_CLEAR_FEATURE, FEAT_ENDPOINT_HALT, 8'h00, 8'h87}, 1'b0, FREE},
         '{'{RT_DEVICE_OUT, REQ_CLEAR_FEATURE, FEAT_REMOTE_WAKEUP, 8'h00, 8'h00}, 1'b0, FREE},
         '{'{RT_DEVICE_OUT, REQ_SET_FEATURE, 8'h02, 8'h00, 8'h00}, 1'b1,
           '{HS_STALL, 8'h00, 8'h00, 2'd0}},
         '{'{RT_ENDPOINT_OUT, REQ_SET_FEATURE, FEAT_REMOTE_WAKEUP, 8'h00, 8'h01}, 1'b1,
           '{HS_STALL, 8'h00, 8'h00, 2'd0}},
         '{'{8'h01, REQ_CLEAR_FEATURE, FEAT_ENDPOINT_HALT, 8'h00, 8'h01}, 1'b1,
           '{HS_STALL, 8'h00, 8'h00, 2'd0}},
         '{'{8'h83, REQ_GET_STATUS, 8'h00, 8'h00, 8'h00}, 1'b1,
           '{HS_STALL, 8'h00, 8'h00, 2'd0}},
         '{'{RT_DEVICE_OUT, REQ_SET_ADDRESS, 8'h7f, 8'h00, 8'h00}, 1'b1,
           '{HS_NONE, 8'h00, 8'h00, 2'd0}},
         '{'{RT_ENDPOINT_IN, REQ_SYNCH_FRAME, 8'h00, 8'h00, 8'h81}, 1'b1,
           '{HS_NONE, 8'h00, 8'h00, 2'd0}},
         '{'{RT_DEVICE_IN, REQ_GET_DESC, 8'hff, 8'hff, 8'hff}, 1'b1,
           '{HS_FORWARD, 8'h00, 8'h00, 2'd0}},
         '{'{RT_DEVICE_IN, REQ_GET_CONFIG, 8'h00, 8'h00, 8'h00}, 1'b1,
           '{HS_ACK, 8'h00, 8'h00, 2'd1}},
         '{'{RT_DEVICE_OUT, REQ_SET_CONFIG, 8'hff, 8'h00, 8'h00}, 1'b1,
           '{HS_ACK, 8'h00, 8'h00, 2'd0}},
         '{'{RT_DEVICE_IN, REQ_GET_CONFIG, 8'h00, 8'h00, 8'h00}, 1'b0, FREE},
         '{'{RT_INTERFACE_IN, REQ_GET_INTERFACE, 8'h00, 8'h00, 8'h00}, 1'b1,
           '{HS_ACK, 8'h00, 8'h00, 2'd1}},
         '{'{8'h01, REQ_SET_INTERFACE, 8'h01, 8'h00, 8'h00}, 1'b1,
           '{HS_ACK, 8'h00, 8'h00, 2'd0}},
         '{'{8'hc0, REQ_PRIVATE_DIAG, 8'h00, 8'h00, 8'h00}, 1'b1,
           '{HS_STALL, 8'h00, 8'h00, 2'd0}},
         '{'{8'hff, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1,
           '{HS_STALL, 8'h00, 8'h00, 2'd0}}
      };
      powered_plan = '{1'b1, 1'b0, 1'b1, 1'b0};
      idle_plan = '{27, 27, 0, 27};

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.request_type = 8'h00;
      req_ch.request_code = 8'h00;
      req_ch.value_low = 8'h00;
      req_ch.value_high = 8'h00;
      req_ch.index_low = 8'h00;
      csr_ch.valid = 1'b0;
      csr_ch.self_powered = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) send_setup(script[i]);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         write_powered(powered_plan[p]);
         idle_pct = idle_plan[p];
         for (int n = 0; n < PHASE_ITEMS; n++) send_setup('{random_setup(), 1'b0, FREE});
         wait_drained();
         idle_pct = 27;
      end

      repeat (10) @(posedge clock);
      while (pending_replies.size() != 0) begin
         log_fault("result never arrived", pending_replies.pop_front(), FREE);
      end

      $display("%0d requests decoded: %0d acknowledged, %0d stalled,",
               accepted, tally[HS_ACK], tally[HS_STALL]);
      $display("   %0d passed on, %0d forwarded", tally[HS_NONE], tally[HS_FORWARD]);
      $display("self powered toggled through both values; %0d faults", fault_count);
      if (fault_count == 0) begin
         $display("usb_standard_request_handler_test OK");
      end else begin
         $display("usb_standard_request_handler_test NOT OK");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout at %0t", $time);
      $display("usb_standard_request_handler_test NOT OK");
      $finish;
   end

endmodule
